[hw/rtl/vmrt_pkg.sv]
// Shared types, codes and default sizes for the region table allocator.
`timescale 1ns / 1ps

package vmrt_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    // The page size is a power of two, so page division is a shift.
    localparam int PAGE_BYTES_DEF  = 4096;

    localparam int ADDR_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STS_W   = 2;
    localparam int PAGES_W = 21;
    // Dividend of the page divider: a 32-bit byte count plus a carry bit.
    localparam int DIV_W   = ADDR_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CFG_IDX_LSB = 2;
    localparam logic [PADDR_W-CFG_IDX_LSB-1:0] CFG_IDX_POOL_BASE = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    clr_scan;
        logic    scan;
        logic    rd_last;
        logic    ld_start;
        logic    div_start;
        logic    wr_alloc;
        logic    wr_swap;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic found;
        logic scan_end;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/vmrt_if.sv]
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps

interface vmrt_req_if import vmrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output command, output request_bytes, output address,
                    input ready);
    modport sink (input valid, input command, input request_bytes, input address,
                  output ready);
endinterface

interface vmrt_rsp_if import vmrt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STS_W-1:0]   status;
    logic [ADDR_W-1:0]  result_address;
    logic [PAGES_W-1:0] page_count;
    logic               is_legal;

    modport source (output valid, output status, output result_address, output page_count,
                    output is_legal, input ready);
    modport sink (input valid, input status, input result_address, input page_count,
                  input is_legal, output ready);
endinterface

[hw/rtl/vmrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vmrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/vmrt_div.sv]
// Page divider by a power-of-two constant: shift and mask, result registered after start.
`timescale 1ns / 1ps

module vmrt_div #(
    parameter int DW      = 33,
    parameter int DIVISOR = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DW-1:0]                  i_dividend,
    output logic                           o_done,
    output logic [DW-1:0]                  o_quot,
    output logic [$clog2(DIVISOR+1)-1:0]   o_rem
);

    localparam int RW = $clog2(DIVISOR + 1);
    // The divisor is a power of two, so its logarithm is the shift distance.
    localparam int SH = $clog2(DIVISOR);

    logic [DW-1:0] r_q;
    logic [RW-1:0] r_rem;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_start) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend >> SH;
            r_rem <= RW'(i_dividend[SH-1:0]);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/vmrt_datapath.sv]
// Region table datapath: table RAM, scan pipeline, page divider and result register.
`timescale 1ns / 1ps

module vmrt_datapath import vmrt_pkg::*; #(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [ADDR_W-1:0]  i_pool_base,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [ADDR_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STS_W-1:0]   o_status,
    output logic [ADDR_W-1:0]  o_result_address,
    output logic [PAGES_W-1:0] o_page_count,
    output logic               o_is_legal
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int ENT_W = 2 * ADDR_W;
    localparam int REM_W = $clog2(PAGE_BYTES + 1);

    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [ADDR_W-1:0] r_hit_start;
    logic [ADDR_W-1:0] r_hit_bytes;
    logic [ADDR_W-1:0] r_new_start;
    logic [DIV_W-1:0]  r_num;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [PAGES_W-1:0] r_out_pages;
    logic               r_out_legal;

    logic [ENT_W-1:0]  rd_data;
    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_bytes;
    logic [CNT_W-1:0]  last_idx;
    logic [IDX_W-1:0]  ram_raddr;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              scan_issue;
    logic              scan_end;
    logic [DIV_W-1:0]  addr_x;
    logic [DIV_W-1:0]  base_x;
    logic              in_meta;
    logic              ent_match;
    logic              take_hit;
    logic [DIV_W-1:0]  div_num;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    logic [REM_W-1:0]  div_rem;
    logic [ADDR_W-1:0] alloc_bytes;
    logic              out_free;
    logic              res_ok;

    assign rd_start = rd_data[ENT_W-1:ADDR_W];
    assign rd_bytes = rd_data[ADDR_W-1:0];
    assign last_idx = r_count - CNT_W'(1);

    // A read is issued per cycle during the scan; the compare follows in the next cycle, on the registered read data.
    assign scan_issue = i_cmd.scan && !r_found && (r_idx < r_count);
    assign scan_end   = r_found || (!r_rd_vld && (r_idx >= r_count));

    assign addr_x  = {1'b0, r_addr};
    assign base_x  = {1'b0, i_pool_base};
    assign in_meta = (addr_x >= base_x) && (addr_x < base_x + DIV_W'(PAGE_BYTES));

    always_comb begin
        if (r_cmd == CMD_RELEASE) begin
            ent_match = (rd_start == r_addr);
        end else begin
            ent_match = (addr_x >= {1'b0, rd_start}) &&
                        (addr_x < {1'b0, rd_start} + {1'b0, rd_bytes});
        end
    end

    assign take_hit = r_rd_vld && !r_found && ent_match;

    assign div_num = (r_cmd == CMD_ALLOC) ? ({1'b0, r_req} + DIV_W'(PAGE_BYTES - 1))
                                          : {1'b0, r_hit_bytes};
    // Rounded length is the rounded-up dividend less its remainder, kept in 32 bits.
    assign alloc_bytes = r_num[ADDR_W-1:0] - ADDR_W'(div_rem);

    assign ram_raddr = i_cmd.rd_last ? last_idx[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign ram_we    = i_cmd.wr_alloc || i_cmd.wr_swap;
    assign ram_waddr = i_cmd.wr_alloc ? r_count[IDX_W-1:0] : r_hit_idx;
    assign ram_wdata = i_cmd.wr_alloc ? {r_new_start, alloc_bytes} : rd_data;

    vmrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    vmrt_div #(
        .DW      (DIV_W),
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign res_ok   = (i_cmd.out_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(1);
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_alloc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.wr_swap) begin
                r_count <= last_idx;
            end
            r_rd_vld <= scan_issue;
            if (i_cmd.clr_scan) begin
                // The metadata page counts as a hit before any entry is read.
                r_found <= (r_cmd == CMD_CHECK) && in_meta;
            end else if (take_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= t_cmd'(i_command);
            r_req  <= i_request_bytes;
            r_addr <= i_address;
        end
        if (i_cmd.clr_scan) begin
            r_idx <= CNT_W'(1);
        end else if (scan_issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_rd_idx <= r_idx[IDX_W-1:0];
        if (take_hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_start <= rd_start;
            r_hit_bytes <= rd_bytes;
        end
        if (i_cmd.ld_start) begin
            r_new_start <= (r_count <= CNT_W'(1)) ? i_pool_base + ADDR_W'(PAGE_BYTES)
                                                  : rd_start + rd_bytes;
        end
        if (i_cmd.div_start) begin
            r_num <= div_num;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (res_ok && (r_cmd == CMD_ALLOC)) begin
                r_out_addr <= r_new_start;
            end else if (res_ok && (r_cmd == CMD_RELEASE)) begin
                r_out_addr <= r_hit_start;
            end else begin
                r_out_addr <= '0;
            end
            r_out_pages <= (res_ok && (r_cmd == CMD_RELEASE)) ? div_quot[PAGES_W-1:0] : '0;
            r_out_legal <= (r_cmd == CMD_CHECK) && r_found;
        end
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.full      = (r_count >= CNT_W'(MAX_REGIONS));
        o_sts.found     = r_found;
        o_sts.scan_end  = scan_end;
        o_sts.div_done  = div_done;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;
    assign o_page_count     = r_out_pages;
    assign o_is_legal       = r_out_legal;

endmodule

[hw/rtl/vmrt_ctrl.sv]
// Controller state machine that sequences allocate, release and check operations.
`timescale 1ns / 1ps

module vmrt_ctrl import vmrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REL_RD,
        S_REL_WR,
        S_ALLOC_LD,
        S_DIV_WAIT,
        S_ALLOC_WR,
        S_RESP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_sts_code;
    t_status n_sts_code;

    always_comb begin
        n_state    = r_state;
        n_sts_code = r_sts_code;
        o_cmd      = '0;
        o_cmd.out_status = r_sts_code;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state    = S_DECODE;
                    n_sts_code = ST_OK;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_ALLOC: begin
                        if (i_sts.full) begin
                            n_sts_code = ST_FULL;
                            n_state    = S_RESP;
                        end else begin
                            // Round the request and fetch the last entry in parallel.
                            o_cmd.div_start = 1'b1;
                            o_cmd.rd_last   = 1'b1;
                            n_state         = S_ALLOC_LD;
                        end
                    end
                    CMD_RELEASE, CMD_CHECK: begin
                        o_cmd.clr_scan = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    if (i_sts.cmd == CMD_CHECK) begin
                        n_state = S_RESP;
                    end else if (i_sts.found) begin
                        n_state = S_REL_RD;
                    end else begin
                        n_sts_code = ST_NOT_FOUND;
                        n_state    = S_RESP;
                    end
                end
            end
            S_REL_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_REL_WR;
            end
            S_REL_WR: begin
                // The last live entry moves into the released slot.
                o_cmd.wr_swap   = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_ALLOC_LD: begin
                o_cmd.ld_start = 1'b1;
                n_state        = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = (i_sts.cmd == CMD_ALLOC) ? S_ALLOC_WR : S_RESP;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.wr_alloc = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sts_code <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_sts_code <= n_sts_code;
        end
    end

endmodule

[hw/rtl/vm_region_table_allocator.sv]
// From input transfer to result load, allocate rounds the request, reads the last entry and
// then writes the new entry; check and release scan live entries one per cycle via the read port.
// One item is in work at a time; the next is taken the cycle after its result is loaded into
// the output register, and a load waits while the previous result still awaits its transfer.
// Reset (synchronous, active low): pool base 0, one table entry reserved, output empty;
// table RAM contents are left undefined and never used before written, so no clearing pass.
`timescale 1ns / 1ps

module vm_region_table_allocator import vmrt_pkg::*; #(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vmrt_req_if.sink           i_req,
    vmrt_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ADDR_W-1:0] r_pool_base;
    logic              cfg_hit;
    logic              cfg_we;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;
    logic              in_ready;

    assign cfg_hit = (paddr[PADDR_W-1:CFG_IDX_LSB] == CFG_IDX_POOL_BASE);
    assign cfg_we  = psel && penable && pwrite && cfg_hit;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? PDATA_W'(r_pool_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (cfg_we) begin
            r_pool_base <= pwdata[ADDR_W-1:0];
        end
    end

    vmrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    assign i_req.ready = in_ready;

    vmrt_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_pool_base      (r_pool_base),
        .i_command        (i_req.command),
        .i_request_bytes  (i_req.request_bytes),
        .i_address        (i_req.address),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_result_address (o_rsp.result_address),
        .o_page_count     (o_rsp.page_count),
        .o_is_legal       (o_rsp.is_legal)
    );

endmodule
